>>> src/indexed_list_store_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the indexed list store checker
// Clocked concurrent assertions, with and without the reset disable.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// Property checked only while out of reset.
`define ILS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked in and out of reset.
`define ILS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> src/ils_pkg.sv
// ---------------------------------------------------------------------------
// Indexed list store package
// Sizes, operation and status codes, and the structs shared between modules.
// ---------------------------------------------------------------------------
package ils_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 6;
    localparam int MODE_W  = 3;
    localparam int WORD_W  = 32;
    localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 48;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_GET    = 3'd4,
        MODE_FIND   = 3'd5,
        MODE_CLEAR  = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT_UP,
        S_PUT,
        S_TAKE,
        S_SHIFT_DN,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } ram_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        status_t                  status;
        logic [CNT_W-1:0]         count;
    } result_t;

endpackage

>>> src/ils_ram.sv
// ---------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module ils_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/ils_ctrl.sv
// ---------------------------------------------------------------------------
// Indexed list store sequencer
// Decodes a request, walks the RAM one entry per cycle and forms the result.
// ---------------------------------------------------------------------------
module ils_ctrl
    import ils_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] in_mode,
    input  logic [POS_W-1:0]  in_pos,
    input  logic [WORD_W-1:0] in_elem,
    output ram_req_t          ram_req,
    input  logic [WORD_W-1:0] ram_rd_data,
    input  logic              out_free,
    output logic              res_load,
    output result_t           res
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [WORD_W-1:0]  elem_reg, elem_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0]  value_reg, value_next;
    status_t            status_reg, status_next;

    logic [CMP_W-1:0]   cnt_w, pos_w, in_pos_w, idx_w;
    logic               cnt_full, cnt_zero;

    assign cnt_w    = CMP_W'(cnt_reg);
    assign pos_w    = CMP_W'(pos_reg);
    assign in_pos_w = CMP_W'(in_pos);
    assign idx_w    = CMP_W'(idx_reg);
    assign cnt_full = (cnt_w == CMP_W'(DEPTH));
    assign cnt_zero = (cnt_reg == '0);

    assign in_ready = (state_reg == S_IDLE);

    assign res.value  = value_reg;
    assign res.status = status_reg;
    assign res.count  = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        elem_reg   <= elem_next;
        idx_reg    <= idx_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        elem_next   = elem_reg;
        idx_next    = idx_reg;
        value_next  = value_reg;
        status_next = status_reg;
        ram_req     = '0;
        res_load    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    pos_next    = in_pos;
                    elem_next   = in_elem;
                    value_next  = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (mode_t'(in_mode))
                        MODE_PUSH, MODE_INSERT: begin
                            if (cnt_full) begin
                                value_next  = '1;
                                status_next = ST_FULL;
                            end else if (mode_t'(in_mode) == MODE_PUSH || in_pos_w >= cnt_w) begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = ADDR_W'(cnt_reg);
                                ram_req.wr_data = in_elem;
                                cnt_next        = cnt_reg + CNT_W'(1);
                            end else begin
                                // open a gap: move entries up from the top down
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = ADDR_W'(cnt_reg - CNT_W'(1));
                                idx_next        = ADDR_W'(cnt_reg - CNT_W'(1));
                                state_next      = S_SHIFT_UP;
                            end
                        end
                        MODE_POP: begin
                            if (cnt_zero) begin
                                value_next  = '1;
                                status_next = ST_MISS;
                            end else begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = ADDR_W'(cnt_reg - CNT_W'(1));
                                cnt_next        = cnt_reg - CNT_W'(1);
                                state_next      = S_READ;
                            end
                        end
                        MODE_GET: begin
                            if (in_pos_w >= cnt_w) begin
                                value_next  = '1;
                                status_next = ST_MISS;
                            end else begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = ADDR_W'(in_pos);
                                state_next      = S_READ;
                            end
                        end
                        MODE_REMOVE: begin
                            if (in_pos_w >= cnt_w) begin
                                value_next  = '1;
                                status_next = ST_MISS;
                            end else begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = ADDR_W'(in_pos);
                                idx_next        = ADDR_W'(in_pos);
                                state_next      = S_TAKE;
                            end
                        end
                        MODE_FIND: begin
                            if (cnt_zero) begin
                                value_next  = '1;
                                status_next = ST_MISS;
                            end else begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = '0;
                                idx_next        = '0;
                                state_next      = S_SCAN;
                            end
                        end
                        MODE_CLEAR: begin
                            cnt_next = '0;
                        end
                        default: begin
                            // unused code: answer ok, leave the list alone
                        end
                    endcase
                end
            end

            S_READ: begin
                value_next = ram_rd_data;
                state_next = S_DONE;
            end

            S_SHIFT_UP: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_reg + ADDR_W'(1);
                ram_req.wr_data = ram_rd_data;
                if (idx_w == pos_w) begin
                    state_next = S_PUT;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_reg - ADDR_W'(1);
                    idx_next        = idx_reg - ADDR_W'(1);
                end
            end

            S_PUT: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = ADDR_W'(pos_reg);
                ram_req.wr_data = elem_reg;
                cnt_next        = cnt_reg + CNT_W'(1);
                state_next      = S_DONE;
            end

            S_TAKE: begin
                value_next = ram_rd_data;
                if (idx_w + CMP_W'(1) < cnt_w) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_reg + ADDR_W'(1);
                    state_next      = S_SHIFT_DN;
                end else begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_SHIFT_DN: begin
                // close the gap: read runs one entry ahead of the write
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = idx_reg;
                ram_req.wr_data = ram_rd_data;
                if (idx_w + CMP_W'(2) < cnt_w) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_reg + ADDR_W'(2);
                    idx_next        = idx_reg + ADDR_W'(1);
                end else begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_SCAN: begin
                if (ram_rd_data == elem_reg) begin
                    value_next = WORD_W'(idx_reg);
                    state_next = S_DONE;
                end else if (idx_w + CMP_W'(1) < cnt_w) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_reg + ADDR_W'(1);
                    idx_next        = idx_reg + ADDR_W'(1);
                end else begin
                    value_next  = '1;
                    status_next = ST_MISS;
                    state_next  = S_DONE;
                end
            end

            S_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/ils_out_reg.sv
// ---------------------------------------------------------------------------
// Indexed list store output register
// Holds one result on the master side until it is taken.
// ---------------------------------------------------------------------------
module ils_out_reg
    import ils_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  result_t          res,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    logic        valid_reg, valid_next;
    result_t     data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_W - WORD_W - 2 - CNT_W){1'b0}},
                       data_reg.count, data_reg.status, data_reg.value};

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

endmodule

>>> src/indexed_list_store.sv
// ---------------------------------------------------------------------------
// Indexed list store
// Bounded ordered list of signed 32-bit words in one RAM, with a count.
// ---------------------------------------------------------------------------
//   channel  | direction | tdata (low bit up)          | tuser
//   s_       | in        | position[5:0] element[31:0] | mode[2:0]
//   m_       | out       | value[31:0] status count    | -
//
// Push, clear, an insert at or past the count, and requests refused or failed
// at decode go straight to the output register; pop and get read the RAM once.
// An insert below the count shifts entries up, remove shifts them down and find
// scans from entry 0: the single RAM read port walks one entry per cycle. Reset
// empties the list at once (count to zero). A stalled output holds its result;
// the next request is taken while it waits and ends once the output frees up.
// ---------------------------------------------------------------------------
module indexed_list_store
    import ils_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // position[5:0], element[37:6]
    input  logic [MODE_W-1:0] s_tuser,   // mode[2:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // value[31:0], status[33:32], count[40:34]
);

    ram_req_t          ram_req;
    logic [WORD_W-1:0] ram_rd_data;
    logic              out_free;
    logic              res_load;
    result_t           res;

    ils_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser),
        .in_pos      (s_tdata[POS_W-1:0]),
        .in_elem     (s_tdata[POS_W +: WORD_W]),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res)
    );

    ils_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    ils_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> src/ils_checker.sv
// ---------------------------------------------------------------------------
// Indexed list store port checker
// Watches the result channel of the top level over time.
// ---------------------------------------------------------------------------
`include "indexed_list_store_macros.svh"

module ils_checker
    import ils_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [WORD_W-1:0] value_f;
    logic [1:0]        status_f;
    logic [CNT_W-1:0]  count_f;

    assign value_f  = m_tdata[WORD_W-1:0];
    assign status_f = m_tdata[WORD_W +: 2];
    assign count_f  = m_tdata[WORD_W + 2 +: CNT_W];

    `ILS_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `ILS_ASSERT(a_full_refusal, m_tvalid && status_f == ST_FULL |-> count_f == CNT_W'(DEPTH) && value_f == '1, "full refusal with list not full")
    `ILS_ASSERT(a_miss_word, m_tvalid && status_f == ST_MISS |-> value_f == '1, "miss without failure word")
    `ILS_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "result shown after reset")

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

>>> bench/tb_indexed_list_store.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Indexed list store testbench
// Drives list operations into the request stream and predicts each result
// with a mirror of the list kept in a scoreboard. A short directed run covers
// the empty-list misses, the value extremes, insert in the middle and past
// the end, remove, find with and without a match, clear and the unused mode.
// Random phases follow: some lean on push and insert to fill the list and hit
// the full refusal, some drain it, others mix lookups. The sender idles in
// bursts and the receiver stalls on its own run pattern.
// ---------------------------------------------------------------------------
module tb_indexed_list_store;
    import ils_pkg::*;

    localparam int                NUM_RANDOM  = 1050;
    localparam int                CYCLE_LIMIT = 600000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    localparam int PH_FILL   = 0;
    localparam int PH_DRAIN  = 1;
    localparam int PH_MIXED  = 2;
    localparam int PH_LOOKUP = 3;

    // Mirror of the list and the queue of results still to come.
    class list_scoreboard;
        logic [WORD_W-1:0] words [DEPTH];
        int                held;
        result_t           awaited [$];
        int                errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                   logic [WORD_W-1:0] elem);
            result_t exp;
            int      i;
            bit      hit;
            exp.value  = '0;
            exp.status = ST_OK;
            hit        = 1'b0;
            case (mode)
                MODE_PUSH, MODE_INSERT: begin
                    if (held >= DEPTH) begin
                        exp.value  = '1;
                        exp.status = ST_FULL;
                    end else begin
                        if (mode == MODE_PUSH || int'(pos) >= held) begin
                            words[ADDR_W'(held)] = elem;
                        end else begin
                            for (i = held; i > int'(pos); i--)
                                words[ADDR_W'(i)] = words[ADDR_W'(i - 1)];
                            words[pos] = elem;
                        end
                        held++;
                    end
                end
                MODE_POP: begin
                    if (held == 0) begin
                        exp.value  = '1;
                        exp.status = ST_MISS;
                    end else begin
                        held--;
                        exp.value = words[ADDR_W'(held)];
                    end
                end
                MODE_REMOVE: begin
                    if (int'(pos) >= held) begin
                        exp.value  = '1;
                        exp.status = ST_MISS;
                    end else begin
                        exp.value = words[pos];
                        for (i = int'(pos); i + 1 < held; i++)
                            words[ADDR_W'(i)] = words[ADDR_W'(i + 1)];
                        held--;
                    end
                end
                MODE_GET: begin
                    if (int'(pos) >= held) begin
                        exp.value  = '1;
                        exp.status = ST_MISS;
                    end else begin
                        exp.value = words[pos];
                    end
                end
                MODE_FIND: begin
                    exp.value  = '1;
                    exp.status = ST_MISS;
                    for (i = 0; i < held && !hit; i++) begin
                        if (words[ADDR_W'(i)] == elem) begin
                            exp.value  = i;
                            exp.status = ST_OK;
                            hit        = 1'b1;
                        end
                    end
                end
                MODE_CLEAR: held = 0;
                default: ;
            endcase
            exp.count = CNT_W'(held);
            awaited.push_back(exp);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            result_t           exp;
            logic [WORD_W-1:0] got_value;
            logic [1:0]        got_status;
            logic [CNT_W-1:0]  got_count;
            got_value  = data[WORD_W-1:0];
            got_status = data[WORD_W+1:WORD_W];
            got_count  = data[WORD_W+2+CNT_W-1:WORD_W+2];
            if (awaited.size() == 0) begin
                $error("result with nothing outstanding: tdata=%h", data);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (got_value !== exp.value) begin
                $error("value: expected %0d, got %0d", $signed(exp.value),
                       $signed(got_value));
                errors++;
            end
            if (got_status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got_status);
                errors++;
            end
            if (got_count !== exp.count) begin
                $error("count: expected %0d, got %0d", exp.count, got_count);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic [MODE_W-1:0] s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    list_scoreboard sb = new();

    bit tx_idle   = 1'b0;
    bit rx_stalls = 1'b0;
    int burst_left = 1;
    int sent_random = 0;
    int cycles = 0;

    indexed_list_store dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: alternate ready and stall runs of random length.
    bit rx_ready_run = 1'b1;
    int rx_run_left  = 0;
    always @(posedge aclk) begin
        if (!rx_stalls) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_run_left == 0) begin
                rx_ready_run = !rx_ready_run;
                rx_run_left  = rx_ready_run ? $urandom_range(1, 10) : $urandom_range(1, 8);
            end else begin
                rx_run_left--;
            end
            m_tready <= rx_ready_run;
        end
    end

    // Note accepted requests before checking results; a result never
    // leaves in the cycle its request enters.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[POS_W-1:0], s_tdata[POS_W+WORD_W-1:POS_W]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Present one request and hold it until accepted, then idle if the burst ran out.
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] elem);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(IN_W-POS_W-WORD_W){1'b0}}, elem, pos};
        do @(posedge aclk); while (!s_tready);
        if (tx_idle) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    // Hold the sender off until every outstanding result is back.
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0 || sb.held == 0)
            return POS_W'($urandom_range(0, 63));
        if (r == 1)
            return ($urandom_range(0, 1) != 0) ? POS_W'(sb.held - 1) :
                   POS_W'((sb.held > 63) ? 63 : sb.held);
        return POS_W'($urandom_range(0, (sb.held > 63) ? 63 : sb.held));
    endfunction

    function automatic logic [WORD_W-1:0] pick_element();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 3 && sb.held > 0)
            return sb.words[ADDR_W'($urandom_range(0, sb.held - 1))];
        if (r == 4)
            return $urandom_range(0, 7);
        if (r == 5)
            return 32'hFFFF_FFF8 | $urandom_range(0, 7);
        if (r == 6) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    task automatic run_phase(input int kind, input int len);
        int                n;
        int                roll;
        logic [MODE_W-1:0] mode;
        for (n = 0; n < len; n++) begin
            roll = $urandom_range(0, 99);
            case (kind)
                PH_FILL:
                    mode = roll < 45 ? MODE_PUSH : roll < 75 ? MODE_INSERT :
                           roll < 85 ? MODE_GET : roll < 93 ? MODE_FIND :
                           roll < 97 ? MODE_POP : MODE_REMOVE;
                PH_DRAIN:
                    mode = roll < 35 ? MODE_POP : roll < 70 ? MODE_REMOVE :
                           roll < 80 ? MODE_PUSH : roll < 88 ? MODE_INSERT :
                           roll < 94 ? MODE_GET : MODE_FIND;
                PH_LOOKUP:
                    mode = roll < 40 ? MODE_FIND : roll < 75 ? MODE_GET :
                           roll < 85 ? MODE_PUSH : roll < 92 ? MODE_INSERT :
                           roll < 96 ? MODE_REMOVE : MODE_POP;
                PH_MIXED:
                    mode = roll < 17 ? MODE_PUSH : roll < 34 ? MODE_INSERT :
                           roll < 48 ? MODE_POP : roll < 64 ? MODE_REMOVE :
                           roll < 80 ? MODE_GET : roll < 96 ? MODE_FIND : MODE_CLEAR;
                default:
                    mode = MODE_GET;
            endcase
            if ($urandom_range(0, 149) == 0)
                mode = MODE_UNUSED;
            send_request(mode, pick_position(), pick_element());
            if (mode != MODE_UNUSED)
                sent_random++;
        end
    endtask

    initial begin
        int phase_no;
        int kind;
        int phase_len;
        phase_no = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: misses on the empty list, extremes, shifts, find, clear.
        rx_stalls = 1'b1;
        send_request(MODE_POP,    6'd0,  32'h0);
        send_request(MODE_GET,    6'd0,  32'h0);
        send_request(MODE_REMOVE, 6'd0,  32'h0);
        send_request(MODE_FIND,   6'd0,  32'h0);
        send_request(MODE_PUSH,   6'd63, 32'h7FFF_FFFF);
        send_request(MODE_PUSH,   6'd0,  32'h8000_0000);
        send_request(MODE_PUSH,   6'd0,  32'hFFFF_FFFF);
        send_request(MODE_INSERT, 6'd0,  32'h0000_0000);
        send_request(MODE_INSERT, 6'd63, 32'h5555_5555);
        send_request(MODE_INSERT, 6'd2,  32'hAAAA_AAAA);
        send_request(MODE_GET,    6'd63, 32'h0);
        send_request(MODE_GET,    6'd0,  32'h0);
        send_request(MODE_FIND,   6'd0,  32'hAAAA_AAAA);
        send_request(MODE_FIND,   6'd0,  32'h1234_5678);
        send_request(MODE_FIND,   6'd0,  32'hFFFF_FFFF);
        send_request(MODE_REMOVE, 6'd1,  32'h0);
        send_request(MODE_REMOVE, 6'd63, 32'h0);
        send_request(MODE_POP,    6'd0,  32'h0);
        send_request(MODE_UNUSED, 6'd21, 32'hDEAD_BEEF);
        send_request(MODE_CLEAR,  6'd42, 32'h0);
        send_request(MODE_POP,    6'd0,  32'h0);
        send_request(MODE_PUSH,   6'd0,  32'h0);
        drain_requests();

        // Random phases; every fourth one fills the list toward the full refusal.
        while (sent_random < NUM_RANDOM) begin
            kind      = (phase_no % 4 == 0) ? PH_FILL : $urandom_range(0, 3);
            tx_idle   = ($urandom_range(0, 2) != 0);
            rx_stalls = ($urandom_range(0, 2) != 0);
            phase_len = (kind == PH_FILL) ? $urandom_range(90, 130) : $urandom_range(30, 110);
            if (phase_len > NUM_RANDOM - sent_random)
                phase_len = NUM_RANDOM - sent_random;
            run_phase(kind, phase_len);
            if ($urandom_range(0, 2) == 0)
                drain_requests();
            phase_no++;
        end

        drain_requests();
        repeat (80) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/ils_pkg.sv
src/ils_ram.sv
src/ils_ctrl.sv
src/ils_out_reg.sv
src/indexed_list_store.sv
src/ils_checker.sv
bench/tb_indexed_list_store.sv
